// ===== hw/rtl/wlste_pkg.sv =====
// ----------------------------------------------------------------------------
// wlste_pkg
// Types and constants shared by the scaled timestamp W-LSB encoder.
// ----------------------------------------------------------------------------
package wlste_pkg;

    localparam int TS_W   = 32;   // timestamp, scaled value, window entry
    localparam int SLOT_W = 4;    // slot field
    localparam int LSB_W  = 6;    // lsb count field
    localparam int DIV_W  = 5;    // divide step counter, 32 steps

    localparam logic [DIV_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_KINIT,
        S_KSRCH,
        S_EMIT,
        S_UPD,
        S_SCAN,
        S_SCAN_END
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item, start divide
        logic div_step;   // one quotient bit
        logic k_init;     // set up k search, read overwritten slot
        logic k_step;     // evaluate one k
        logic emit;       // load output register
        logic upd;        // write slot, update min/max
        logic scan_rd;    // read one window entry for rescan
        logic scan_end;   // commit rescanned bound
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stride_zero;
        logic div_last;
        logic k_done;
        logic out_free;
        logic rescan;
        logic scan_last;
    } t_sts;

endpackage

// ===== hw/rtl/wlste_if.sv =====
// ----------------------------------------------------------------------------
// wlste_if
// Valid/ready channels of the encoder: input items, results, stride writes.
// ----------------------------------------------------------------------------
interface wlste_in_if import wlste_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TS_W-1:0]   timestamp;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output timestamp, output slot, input ready);
    modport sink   (input valid, input timestamp, input slot, output ready);
endinterface

interface wlste_out_if import wlste_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  scaled_value;
    logic [LSB_W-1:0] lsb_count;

    modport source (output valid, output scaled_value, output lsb_count, input ready);
    modport sink   (input valid, input scaled_value, input lsb_count, output ready);
endinterface

interface wlste_cfg_if import wlste_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wlsb_scaled_ts_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// wlsb_scaled_ts_encoder_unit
// Each item goes through the divider, one quotient bit per cycle, then the k
// search, one k per cycle, trying up to MAX_LSB_BITS-2 values of k.
// A new item is taken only after the last is emitted and written, and after a
// rescan through the RAM port when the overwritten entry held the window min or max.
// Reset clears stride, window min/max, window valid bits and result valid.
// ----------------------------------------------------------------------------
module wlsb_scaled_ts_encoder_unit import wlste_pkg::*; #(
    parameter int WINDOW_DEPTH = 16,
    parameter int MAX_LSB_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wlste_in_if.sink    i_in,
    wlste_cfg_if.sink   i_cfg,
    wlste_out_if.source o_res
);

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    wlste_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wlste_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_LSB_BITS (MAX_LSB_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .i_timestamp    (i_in.timestamp),
        .i_slot         (i_in.slot),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_scaled_value (o_res.scaled_value),
        .o_lsb_count    (o_res.lsb_count)
    );

endmodule

// ===== hw/rtl/wlste_ram.sv =====
// ----------------------------------------------------------------------------
// wlste_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wlste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/wlste_ctrl.sv =====
// ----------------------------------------------------------------------------
// wlste_ctrl
// Sequencer: divide, k search, emit, window write and optional rescan.
// ----------------------------------------------------------------------------
module wlste_ctrl import wlste_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                // zero stride: item is taken and dropped
                if (i_in_valid && !i_sts.stride_zero) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_KINIT;
                end
            end
            S_KINIT: begin
                o_cmd.k_init = 1'b1;
                n_state      = S_KSRCH;
            end
            S_KSRCH: begin
                o_cmd.k_step = 1'b1;
                if (i_sts.k_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.rescan ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                o_cmd.scan_end = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/wlste_dp.sv =====
// ----------------------------------------------------------------------------
// wlste_dp
// Datapath: stride register, restoring divider, k search against window
// min/max, result register, window RAM with valid bits and min/max rescan.
// ----------------------------------------------------------------------------
module wlste_dp import wlste_pkg::*; #(
    parameter int WINDOW_DEPTH = 16,
    parameter int MAX_LSB_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_valid,
    input  logic [TS_W-1:0]   i_cfg_data,
    input  logic [TS_W-1:0]   i_timestamp,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [TS_W-1:0]   o_scaled_value,
    output logic [LSB_W-1:0]  o_lsb_count
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int CW = AW + 1;
    localparam logic [LSB_W-1:0] K_MAX  = LSB_W'(MAX_LSB_BITS);
    localparam logic [LSB_W-1:0] K_LAST = LSB_W'(MAX_LSB_BITS - 1);

    // stride
    logic [TS_W-1:0] r_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= '0;
        end else if (i_cfg_valid) begin
            r_stride <= i_cfg_data;
        end
    end

    // divider, one quotient bit per cycle; slot folded into range alongside
    logic [TS_W:0]    r_rem;
    logic [TS_W-1:0]  r_quo;
    logic [DIV_W-1:0] r_dcnt;
    logic [SW-1:0]    r_idx;
    logic [TS_W:0]    rem_sh;
    logic             rem_ge;
    logic [AW-1:0]    idx;

    assign rem_sh = {r_rem[TS_W-1:0], r_quo[TS_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_stride});
    assign idx    = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= '0;
            r_quo  <= i_timestamp;
            r_dcnt <= '0;
            r_idx  <= SW'(i_slot);
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? (rem_sh - {1'b0, r_stride}) : rem_sh;
            r_quo  <= {r_quo[TS_W-2:0], rem_ge};
            r_dcnt <= r_dcnt + 1'b1;
            if ({1'b0, r_idx} >= (SW + 1)'(WINDOW_DEPTH)) begin
                r_idx <= r_idx - SW'(WINDOW_DEPTH);
            end
        end
    end

    // window bounds
    logic [TS_W-1:0] r_min;
    logic [TS_W-1:0] r_max;
    logic [TS_W-1:0] scaled;

    assign scaled = r_quo;

    // k search, one k per cycle for both references
    logic [LSB_W-1:0] r_k;
    logic [TS_W-1:0]  r_p;      // 2^(k-2)-1
    logic [TS_W-1:0]  r_q;      // 3*2^(k-2)
    logic             r_fmin;
    logic             r_fmax;
    logic [LSB_W-1:0] r_kmin;
    logic [LSB_W-1:0] r_kmax;
    logic             hit_min;
    logic             hit_max;

    assign hit_min = ($signed(scaled) <= $signed(r_min + r_q)) &&
                     ($signed(r_min - r_p) <= $signed(scaled));
    assign hit_max = ($signed(scaled) <= $signed(r_max + r_q)) &&
                     ($signed(r_max - r_p) <= $signed(scaled));

    always_ff @(posedge i_clk) begin
        if (i_cmd.k_init) begin
            r_k    <= LSB_W'(2);
            r_p    <= '0;
            r_q    <= TS_W'(3);
            r_fmin <= (r_min == scaled);
            r_fmax <= (r_max == scaled);
            r_kmin <= (r_min == scaled) ? '0 : K_MAX;
            r_kmax <= (r_max == scaled) ? '0 : K_MAX;
        end else if (i_cmd.k_step) begin
            r_k <= r_k + 1'b1;
            r_p <= {r_p[TS_W-2:0], 1'b1};
            r_q <= {r_q[TS_W-2:0], 1'b0};
            if (!r_fmin && hit_min) begin
                r_fmin <= 1'b1;
                r_kmin <= r_k;
            end
            if (!r_fmax && hit_max) begin
                r_fmax <= 1'b1;
                r_kmax <= r_k;
            end
        end
    end

    // result register
    logic             r_out_valid;
    logic [TS_W-1:0]  r_out_scaled;
    logic [LSB_W-1:0] r_out_lsb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_scaled <= scaled;
            r_out_lsb    <= (r_kmin < r_kmax) ? r_kmax : r_kmin;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scaled_value = r_out_scaled;
    assign o_lsb_count    = r_out_lsb;

    // window store; an entry never written reads as zero
    logic [WINDOW_DEPTH-1:0] r_vld;
    logic                    r_rd_vld;
    logic                    r_pend;
    logic [CW-1:0]           r_scnt;
    logic                    r_scan_min;
    logic [TS_W-1:0]         r_acc;
    logic [TS_W-1:0]         n_acc;
    logic [TS_W-1:0]         rdata;
    logic [TS_W-1:0]         rd_val;
    logic [TS_W-1:0]         acc_op;
    logic [AW-1:0]           raddr;
    logic                    ram_re;
    logic                    eq_min;
    logic                    eq_max;

    assign raddr  = i_cmd.scan_rd ? r_scnt[AW-1:0] : idx;
    assign ram_re = i_cmd.scan_rd || i_cmd.k_init;
    assign rd_val = r_rd_vld ? rdata : '0;
    assign eq_min = (rd_val == r_min);
    assign eq_max = (rd_val == r_max);
    assign acc_op = r_scan_min ? ((rd_val < r_acc) ? rd_val : r_acc)
                               : ((rd_val > r_acc) ? rd_val : r_acc);
    assign n_acc  = r_pend ? acc_op : r_acc;

    wlste_ram #(
        .WIDTH (TS_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (idx),
        .i_wdata (scaled),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.upd) begin
            r_vld[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= i_cmd.scan_rd;
        if (ram_re) begin
            r_rd_vld <= r_vld[raddr];
        end
        if (i_cmd.upd) begin
            r_scnt     <= '0;
            r_scan_min <= eq_min;
            r_acc      <= eq_min ? {TS_W{1'b1}} : '0;
        end else begin
            r_acc <= n_acc;
            if (i_cmd.scan_rd) begin
                r_scnt <= r_scnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_cmd.upd) begin
            // overwritten entry held a bound: that bound is rescanned later (the min only, when it held both)
            if (!eq_min && scaled < r_min) begin
                r_min <= scaled;
            end
            if ((eq_min || !eq_max) && scaled > r_max) begin
                r_max <= scaled;
            end
        end else if (i_cmd.scan_end) begin
            if (r_scan_min) begin
                r_min <= n_acc;
            end else begin
                r_max <= n_acc;
            end
        end
    end

    assign o_sts.stride_zero = (r_stride == '0);
    assign o_sts.div_last    = (r_dcnt == DIV_LAST);
    assign o_sts.k_done      = (r_fmin && r_fmax) || (r_k == K_LAST);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.rescan      = eq_min || eq_max;
    assign o_sts.scan_last   = (r_scnt == CW'(WINDOW_DEPTH - 1));

endmodule

// ===== dv/wlste_encode_check.sv =====
// ----------------------------------------------------------------------------
// wlste_encode_check
// Watches the item, stride and result channels of the scaled timestamp W-LSB
// encoder. Keeps its own copy of the stride, the window and its min/max, and
// predicts scaled value and LSB count for every item taken in under a nonzero stride. Results
// are compared in order against the predicted encodings.
// ----------------------------------------------------------------------------
module wlste_encode_check import wlste_pkg::*; #(
    parameter int WINDOW_DEPTH = 16,
    parameter int MAX_LSB_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wlste_in_if   i_in,
    wlste_cfg_if  i_cfg,
    wlste_out_if  i_res,
    output int    o_errors,
    output int    o_pending,
    output int    o_items,
    output int    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TS_W-1:0]  scaled;
        logic [LSB_W-1:0] lsbs;
    } t_encoding;

    logic [TS_W-1:0] stride_reg;
    logic [TS_W-1:0] win [WINDOW_DEPTH];
    logic [TS_W-1:0] win_min;
    logic [TS_W-1:0] win_max;
    t_encoding       enc_q [$];
    int              err_cnt;
    int              item_cnt;
    int              chk_cnt;
    int              pend_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = pend_cnt;
    assign o_items   = item_cnt;
    assign o_checked = chk_cnt;

    // fewest LSBs k such that val falls in [ref-p, ref+2^k-1-p], signed compare
    function automatic logic [LSB_W-1:0] lsbs_for_ref(input logic [TS_W-1:0] ref_v,
                                                      input logic [TS_W-1:0] val);
        logic [TS_W-1:0] p;
        logic [TS_W-1:0] span;
        logic [TS_W-1:0] lo;
        logic [TS_W-1:0] hi;
        int k;
        if (ref_v == val) return '0;
        for (k = 2; k < MAX_LSB_BITS; k++) begin
            p    = TS_W'((64'd1 << (k - 2)) - 64'd1);
            span = TS_W'((64'd1 << k) - 64'd1);
            lo   = ref_v - p;
            hi   = ref_v + span - p;
            if ($signed(val) <= $signed(hi) && $signed(lo) <= $signed(val))
                return LSB_W'(k);
        end
        return LSB_W'(MAX_LSB_BITS);
    endfunction

    always @(posedge i_clk) begin
        t_encoding       want;
        logic [TS_W-1:0] scaled;
        logic [TS_W-1:0] cur;
        logic [LSB_W-1:0] k_min;
        logic [LSB_W-1:0] k_max;
        int              idx;
        int              i;
        if (!i_rst_n) begin
            stride_reg = '0;
            for (i = 0; i < WINDOW_DEPTH; i++) win[i] = '0;
            win_min  = '0;
            win_max  = '0;
            enc_q.delete();
            err_cnt  = 0;
            item_cnt = 0;
            chk_cnt  = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (enc_q.size() == 0) begin
                    $error("result with none expected: scaled_value=%0h lsb_count=%0d",
                           i_res.scaled_value, i_res.lsb_count);
                    err_cnt++;
                end else begin
                    want = enc_q.pop_front();
                    chk_cnt++;
                    if (i_res.scaled_value !== want.scaled) begin
                        $error("scaled_value: expected %0h, got %0h",
                               want.scaled, i_res.scaled_value);
                        err_cnt++;
                    end
                    if (i_res.lsb_count !== want.lsbs) begin
                        $error("lsb_count: expected %0d, got %0d",
                               want.lsbs, i_res.lsb_count);
                        err_cnt++;
                    end
                end
            end

            if (i_cfg.valid && i_cfg.ready)
                stride_reg = i_cfg.data;

            if (i_in.valid && i_in.ready) begin
                item_cnt++;
                // zero stride: item dropped, window untouched
                if (stride_reg != '0) begin
                    scaled = i_in.timestamp / stride_reg;
                    k_min  = lsbs_for_ref(win_min, scaled);
                    k_max  = lsbs_for_ref(win_max, scaled);
                    want.scaled = scaled;
                    want.lsbs   = (k_min < k_max) ? k_max : k_min;
                    enc_q.push_back(want);

                    idx      = int'(i_in.slot) % WINDOW_DEPTH;
                    cur      = win[idx];
                    win[idx] = scaled;
                    if (cur != win_min && cur != win_max) begin
                        if (scaled < win_min) win_min = scaled;
                        if (scaled > win_max) win_max = scaled;
                    end else if (cur == win_min) begin
                        // also taken when cur was both min and max
                        win_min = win[0];
                        for (i = 1; i < WINDOW_DEPTH; i++)
                            if (win[i] < win_min) win_min = win[i];
                        if (scaled > win_max) win_max = scaled;
                    end else begin
                        win_max = win[0];
                        for (i = 1; i < WINDOW_DEPTH; i++)
                            if (win[i] > win_max) win_max = win[i];
                        if (scaled < win_min) win_min = scaled;
                    end
                end
            end
        end
        pend_cnt = enc_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the scaled timestamp W-LSB encoder: directed corner items, then
// timestamp streams with random content under several strides and idle
// patterns, a zero stride stretch and a long result back-pressure window.
// Checking is done by wlste_encode_check.
// ----------------------------------------------------------------------------
module tb_top import wlste_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH   = 16;
    localparam int MAX_LSBS    = 32;
    localparam int LAT_CYCLES  = 100;   // worst item latency plus rescan, with margin
    localparam int HOLD_CYCLES = 400;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle;

    logic clk;
    logic rst_n;
    logic hold_off;
    int   gap_pct;
    int   stall_pct;
    int   errors;
    int   pending;
    int   items;
    int   checked;
    int   stride_writes;

    wlste_in_if  item_ch ();
    wlste_cfg_if stride_ch ();
    wlste_out_if enc_ch ();

    wlsb_scaled_ts_encoder_unit #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .MAX_LSB_BITS (MAX_LSBS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (item_ch),
        .i_cfg   (stride_ch),
        .o_res   (enc_ch)
    );

    wlste_encode_check #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .MAX_LSB_BITS (MAX_LSBS)
    ) u_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (item_ch),
        .i_cfg     (stride_ch),
        .i_res     (enc_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_items   (items),
        .o_checked (checked)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial begin
        enc_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            enc_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("wlsb_scaled_ts_encoder_unit test failed");
        $finish;
    end

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SRC:  begin gap_pct = 66; stall_pct = 0;  end
            IDLE_SNK:  begin gap_pct = 0;  stall_pct = 66; end
            default:   begin gap_pct = 17; stall_pct = 17; end
        endcase
    endtask

    // valid stays high across back-to-back transfers; dropped only in a gap
    task automatic send_item(input logic [TS_W-1:0] ts, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(0, 99) < gap_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.timestamp <= ts;
        item_ch.slot      <= slot;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // lower valid and wait for the checker to count the last transfer, then for pending to empty
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    task automatic write_stride(input logic [TS_W-1:0] value);
        drain();
        stride_ch.valid <= 1'b1;
        stride_ch.data  <= value;
        do @(posedge clk); while (!stride_ch.ready);
        stride_ch.valid <= 1'b0;
        stride_writes++;
    endtask

    // packet-like timestamp runs with cyclic slots, plus jumps, steps back and noise
    task automatic send_stream(input int count, input logic [TS_W-1:0] stride_v);
        logic [TS_W-1:0]   base;
        logic [TS_W-1:0]   delta;
        logic [TS_W-1:0]   ts;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] slot_ptr;
        int n;
        int run_left;
        int dice;
        int i;
        run_left = 0;
        slot_ptr = '0;
        n        = 0;
        base     = '0;
        delta    = '0;
        for (i = 0; i < count; i++) begin
            if (run_left == 0) begin
                base     = $urandom;
                delta    = stride_v * TS_W'($urandom_range(1, 4));
                n        = 0;
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            n++;
            dice = $urandom_range(0, 99);
            if (dice < 10) begin
                ts   = $urandom;
                slot = SLOT_W'($urandom);
            end else begin
                if (dice < 16)
                    base = base + (stride_v << $urandom_range(0, 31));
                else if (dice < 20)
                    n = n - $urandom_range(1, 8);
                ts = base + delta * TS_W'(n);
                if (dice % 3 == 0)
                    ts = ts + ($urandom % stride_v);
                slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom) : slot_ptr;
                slot_ptr++;
            end
            send_item(ts, slot);
        end
    endtask

    initial begin
        logic [TS_W-1:0] phase_strides [8];
        int ph;
        int i;
        phase_strides = '{32'd1, 32'd160, 32'd7, 32'd3000,
                          32'd90000, 32'd1, 32'hFFFF_FFFF, 32'd0};
        rst_n               <= 1'b0;
        hold_off            <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.timestamp   <= '0;
        item_ch.slot        <= '0;
        stride_ch.valid     <= 1'b0;
        stride_ch.data      <= '0;
        stride_writes       = 0;
        set_idle(IDLE_NONE);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // zero stride: nothing comes out, window must stay cleared
        write_stride(32'd0);
        send_item(32'hFFFF_FFFF, 4'd15);
        send_item(32'h1234_5678, 4'd3);

        write_stride(32'd1);
        send_item(32'd0, 4'd0);             // equals both refs, entry is min and max
        send_item(32'd1, 4'd1);
        send_item(32'hFFFF_FFFF, 4'd15);    // -1 against 0 and 1
        send_item(32'h7FFF_FFFF, 4'd2);
        send_item(32'h8000_0000, 4'd3);     // no k fits
        send_item(32'd3, 4'd15);            // overwrites the max
        send_item(32'd5, 4'd0);             // overwrites the min
        send_item(32'd6, 4'd1);
        send_item(32'd7, 4'd4);
        send_item(32'd7, 4'd5);
        send_item(32'h0000_0010, 4'd10);
        send_item(32'h8000_0000, 4'd3);     // rewrite of the max slot with same value
        send_item(32'h0000_0000, 4'd7);

        write_stride(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 4'd0);
        send_item(32'hFFFF_FFFE, 4'd5);
        send_item(32'd0, 4'd7);

        write_stride(32'h8000_0000);
        send_item(32'hFFFF_FFFF, 4'd8);
        send_item(32'h8000_0000, 4'd9);
        send_item(32'h7FFF_FFFF, 4'd14);

        for (ph = 0; ph < 8; ph++) begin
            if (ph == 7)
                phase_strides[ph] = $urandom_range(2, 1 << 16);
            write_stride(phase_strides[ph]);
            set_idle(t_idle'(ph % 4));
            send_stream((phase_strides[ph] == 32'hFFFF_FFFF) ? 40 : 215, phase_strides[ph]);
        end

        write_stride(32'd0);
        set_idle(IDLE_BOTH);
        for (i = 0; i < 30; i++)
            send_item($urandom, SLOT_W'($urandom));

        // results held off while items keep coming, so the input stalls
        write_stride(32'd1);
        set_idle(IDLE_NONE);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_stream(60, 32'd1);
        join

        drain();
        $display("Ran %0d input items under %0d stride writes (zero, one, all-ones, random),",
                 items, stride_writes);
        $display("with source/sink idling and a long sink hold-off; %0d encodings compared.",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("wlsb_scaled_ts_encoder_unit test passed");
        end else begin
            $display("wlsb_scaled_ts_encoder_unit test failed");
        end
        $finish;
    end

endmodule
